// ===== design/run_queue_latency_histogram_core_macros.svh =====
// Assertion macros for the run-queue latency histogram core.
// Used by the checker module; needs clk and arst_n in the enclosing scope.
`ifndef RUN_QUEUE_LATENCY_HISTOGRAM_CORE_MACROS_SVH
`define RUN_QUEUE_LATENCY_HISTOGRAM_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RQLH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RQLH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rqlh_pkg.sv =====
// Shared types and constants for the run-queue latency histogram core.
// No dependencies; the design files that use it refer to it by scoped names.
package rqlh_pkg;

	localparam int TABLE_ENTRIES_DEF = 8192;
	localparam int PROBE_LIMIT_DEF   = 8;
	localparam int NUM_BINS          = 32;
	localparam int BIN_W             = 5;
	localparam int MAX_BIN           = 31;
	localparam int TASK_W            = 22;
	localparam int TIME_W            = 64;
	localparam int REQ_W             = 2;
	localparam int STAT_W            = 2;
	localparam int NS_PER_US         = 1000;
	localparam logic [31:0] HASH_MULT = 32'h9E3779B1;
	// One table word: valid flag, task id and wake time.
	localparam int SLOT_W            = 1 + TASK_W + TIME_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_WAKE   = 2'd0,
		REQ_SWITCH = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_DROP  = 2'd1,
		ST_NOREC = 2'd2
	} stat_t;

	typedef struct packed {
		req_t               req;
		logic [TASK_W-1:0]  task_id;
		logic [TIME_W-1:0]  time_ns;
		logic [BIN_W-1:0]   sel;
	} item_t;

	typedef struct packed {
		logic clr_done;
		logic pop;
	} bk_ctrl_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_MOD,
		S_RD,
		S_CK,
		S_DECIDE,
		S_LAT,
		S_BIN
	} bk_state_t;

endpackage

// ===== design/rqlh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rqlh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/rqlh_div.sv =====
// Constant-divisor arithmetic: home slot by reciprocal multiplication and the
// log2 microsecond bucket by threshold compares. Uses rqlh_pkg.
module rqlh_div #(
	parameter int TABLE_ENTRIES = rqlh_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic [31:0]                         hash,
	output logic [$clog2(TABLE_ENTRIES)-1:0]    home,
	input  logic [rqlh_pkg::TIME_W-1:0]         delta,
	output logic [rqlh_pkg::BIN_W-1:0]          bucket
);

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int SHIFT   = 32 + IDX_W;
	localparam int RECIP_W = 34;
	// Rounded-up reciprocal; exact quotient for every 32-bit hash.
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << SHIFT) + 64'(TABLE_ENTRIES - 1)) / 64'(TABLE_ENTRIES);
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_FULL[RECIP_W-1:0];
	localparam logic [31:0]        ENTRIES = 32'(TABLE_ENTRIES);

	logic [31+RECIP_W:0] prod;
	logic [31:0]         quo_q;
	logic [31:0]         rem;

	// Quotient of the hash by the table size, registered; the hash is held while the remainder is formed.
	always_comb begin
		prod = {{RECIP_W{1'b0}}, hash} * {32'd0, RECIP};
	end

	always_ff @(posedge clk) begin
		quo_q <= 32'(prod >> SHIFT);
	end

	// Remainder from the registered quotient.
	always_comb begin
		rem  = hash - (quo_q * ENTRIES);
		home = rem[IDX_W-1:0];
	end

	// Microseconds reach 2^b exactly when the nanoseconds reach 1000 * 2^b.
	always_comb begin
		bucket = '0;
		for (int b = 1; b <= rqlh_pkg::MAX_BIN; b++) begin
			if (delta >= (64'(rqlh_pkg::NS_PER_US) << b)) begin
				bucket = rqlh_pkg::BIN_W'(b);
			end
		end
	end

endmodule

// ===== design/rqlh_front.sv =====
// Front end: accepts requests and queues them two deep.
// Uses rqlh_pkg.
module rqlh_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rqlh_pkg::REQ_W-1:0]       req_type,
	input  logic [rqlh_pkg::TASK_W-1:0]      task_id,
	input  logic [rqlh_pkg::TIME_W-1:0]      time_ns,
	input  logic [rqlh_pkg::BIN_W-1:0]       bin_select,
	input  rqlh_pkg::bk_ctrl_t               bk_ctrl,
	output logic                             q_valid,
	output rqlh_pkg::item_t                  q_head
);

	rqlh_pkg::item_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;
	logic            pop;

	// Requests are held off while the table clear runs or the queue is full.
	assign in_ready = (cnt_q != 2'd2) && bk_ctrl.clr_done;
	assign push     = in_valid && in_ready;
	assign pop      = bk_ctrl.pop && (cnt_q != 2'd0);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = fifo_q[rd_ptr_q];

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{req: rqlh_pkg::req_t'(req_type), task_id: task_id,
				time_ns: time_ns, sel: bin_select};
		end
	end

endmodule

// ===== design/rqlh_back.sv =====
// Back end: hash probe of the wake-time table, latency binning, histogram.
// Uses rqlh_pkg, rqlh_ram and rqlh_div.
module rqlh_back #(
	parameter int TABLE_ENTRIES = rqlh_pkg::TABLE_ENTRIES_DEF,
	parameter int PROBE_LIMIT   = rqlh_pkg::PROBE_LIMIT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  rqlh_pkg::item_t                q_head,
	output rqlh_pkg::bk_ctrl_t             bk_ctrl,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rqlh_pkg::STAT_W-1:0]    status,
	output logic [rqlh_pkg::BIN_W-1:0]     bin_index,
	output logic [rqlh_pkg::TIME_W-1:0]    bin_count
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;

	rqlh_pkg::bk_state_t             state_q, state_d;
	rqlh_pkg::item_t                 item_q;
	logic [31:0]                     prod_q;
	logic [IDX_W-1:0]                slot_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            hit_q;
	logic [IDX_W-1:0]                hit_slot_q;
	logic [rqlh_pkg::TIME_W-1:0]     hit_time_q;
	logic                            free_q;
	logic [IDX_W-1:0]                free_slot_q;
	logic [IDX_W-1:0]                clr_addr_q;
	logic [rqlh_pkg::TIME_W-1:0]     delta_q;
	logic [rqlh_pkg::BIN_W-1:0]      bucket_q;
	logic [rqlh_pkg::TIME_W-1:0]     bins_q [rqlh_pkg::NUM_BINS];
	logic                            out_valid_q;
	logic [rqlh_pkg::STAT_W-1:0]     status_q;
	logic [rqlh_pkg::BIN_W-1:0]      bin_index_q;
	logic [rqlh_pkg::TIME_W-1:0]     bin_count_q;
	logic                            pop;
	logic                            clr_done;

	logic                            ram_we;
	logic [IDX_W-1:0]                ram_waddr;
	logic [rqlh_pkg::SLOT_W-1:0]     ram_wdata;
	logic [IDX_W-1:0]                ram_raddr;
	logic [rqlh_pkg::SLOT_W-1:0]     ram_rdata;
	logic                            rd_valid;
	logic [rqlh_pkg::TASK_W-1:0]     rd_task;
	logic [rqlh_pkg::TIME_W-1:0]     rd_time;

	logic [IDX_W-1:0]                home;
	logic [rqlh_pkg::BIN_W-1:0]      bucket;
	logic [IDX_W-1:0]                slot_next;

	rqlh_ram #(
		.WIDTH(rqlh_pkg::SLOT_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	rqlh_div #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_div (
		.clk   (clk),
		.hash  (prod_q),
		.home  (home),
		.delta (delta_q),
		.bucket(bucket)
	);

	assign {rd_valid, rd_task, rd_time} = ram_rdata;
	assign clr_done  = (state_q != rqlh_pkg::S_CLEAR);
	assign bk_ctrl   = '{clr_done: clr_done, pop: pop};
	assign slot_next = (slot_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : slot_q + 1'b1;

	// Next state and table port.
	always_comb begin
		state_d      = state_q;
		pop          = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = hit_slot_q;
		ram_wdata    = {1'b1, item_q.task_id, item_q.time_ns};
		ram_raddr    = slot_q;
		unique case (state_q)
			rqlh_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = '0;
				if (clr_addr_q == IDX_W'(TABLE_ENTRIES - 1)) begin
					state_d = rqlh_pkg::S_IDLE;
				end
			end
			rqlh_pkg::S_IDLE: begin
				if (q_valid && !out_valid_q) begin
					pop = 1'b1;
					case (q_head.req) inside
						rqlh_pkg::REQ_WAKE, rqlh_pkg::REQ_SWITCH: state_d = rqlh_pkg::S_HASH;
						default: state_d = rqlh_pkg::S_IDLE;
					endcase
				end
			end
			rqlh_pkg::S_HASH: begin
				state_d = rqlh_pkg::S_MOD;
			end
			rqlh_pkg::S_MOD: begin
				state_d = rqlh_pkg::S_RD;
			end
			rqlh_pkg::S_RD: begin
				state_d = rqlh_pkg::S_CK;
			end
			rqlh_pkg::S_CK: begin
				if (cnt_q == CNT_W'(PROBE_LIMIT - 1)) begin
					state_d = rqlh_pkg::S_DECIDE;
				end else begin
					state_d = rqlh_pkg::S_RD;
				end
			end
			rqlh_pkg::S_DECIDE: begin
				state_d = rqlh_pkg::S_IDLE;
				if (item_q.req == rqlh_pkg::REQ_WAKE) begin
					if (hit_q) begin
						ram_we = 1'b1;
					end else if (free_q) begin
						ram_we    = 1'b1;
						ram_waddr = free_slot_q;
					end
				end else if (hit_q) begin
					// Free the entry; the latency is binned next.
					ram_we    = 1'b1;
					ram_wdata = '0;
					state_d   = rqlh_pkg::S_LAT;
				end
			end
			rqlh_pkg::S_LAT: begin
				state_d = rqlh_pkg::S_BIN;
			end
			rqlh_pkg::S_BIN: begin
				state_d = rqlh_pkg::S_IDLE;
			end
			default: state_d = rqlh_pkg::S_IDLE;
		endcase
	end

	// State register, clear sweep, histogram bins and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rqlh_pkg::S_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < rqlh_pkg::NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == rqlh_pkg::S_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == rqlh_pkg::S_IDLE && pop &&
				(q_head.req == rqlh_pkg::REQ_READ || q_head.req == rqlh_pkg::REQ_NONE)) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == rqlh_pkg::S_DECIDE && state_d == rqlh_pkg::S_IDLE) begin
				out_valid_q <= 1'b1;
			end
			if (state_q == rqlh_pkg::S_BIN) begin
				bins_q[bucket_q] <= bins_q[bucket_q] + 1'b1;
				out_valid_q      <= 1'b1;
			end
		end
	end

	// Per-request working registers and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			rqlh_pkg::S_IDLE: begin
				if (pop) begin
					item_q      <= q_head;
					prod_q      <= 32'(q_head.task_id * rqlh_pkg::HASH_MULT);
					status_q    <= rqlh_pkg::ST_OK;
					bin_index_q <= '0;
					bin_count_q <= '0;
					if (q_head.req == rqlh_pkg::REQ_READ) begin
						bin_index_q <= q_head.sel;
						bin_count_q <= bins_q[q_head.sel];
					end
				end
			end
			rqlh_pkg::S_MOD: begin
				slot_q <= home;
				cnt_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end
			rqlh_pkg::S_CK: begin
				// First matching slot and first free slot of the window.
				if (rd_valid && rd_task == item_q.task_id && !hit_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= slot_q;
					hit_time_q <= rd_time;
				end
				if (!rd_valid && !free_q) begin
					free_q      <= 1'b1;
					free_slot_q <= slot_q;
				end
				slot_q <= slot_next;
				cnt_q  <= cnt_q + 1'b1;
			end
			rqlh_pkg::S_DECIDE: begin
				delta_q <= item_q.time_ns - hit_time_q;
				if (item_q.req == rqlh_pkg::REQ_WAKE) begin
					if (!hit_q && !free_q) begin
						status_q <= rqlh_pkg::ST_DROP;
					end
				end else if (!hit_q) begin
					status_q <= rqlh_pkg::ST_NOREC;
				end
			end
			rqlh_pkg::S_LAT: begin
				bucket_q <= bucket;
			end
			rqlh_pkg::S_BIN: begin
				bin_index_q <= bucket_q;
				bin_count_q <= bins_q[bucket_q] + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bin_index = bin_index_q;
	assign bin_count = bin_count_q;

endmodule

// ===== design/run_queue_latency_histogram_core.sv =====
// Run-queue latency histogram: wakeup, switch and bin-read requests in, one result per request.
// After reset the block clears its wake-time table, one entry per cycle, and accepts no request
// until that is done. A bin read or an unused request code shows its result in the cycle after
// the back end takes it from the queue. A wakeup, or a switch without a record, is started and
// its hash formed, the hash is reduced to a home slot by reciprocal multiplication, each probe
// slot gets a table read and a compare, and then the outcome is decided and the table written.
// A switch that finds its record then bins the latency by threshold compares and updates the
// histogram. Two requests queue in front while one is being worked on; a finished result is held
// in an output register until taken, and the next request starts the cycle after that.
module run_queue_latency_histogram_core #(
	parameter int TABLE_ENTRIES = rqlh_pkg::TABLE_ENTRIES_DEF,
	parameter int PROBE_LIMIT   = rqlh_pkg::PROBE_LIMIT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rqlh_pkg::REQ_W-1:0]     req_type,
	input  logic [rqlh_pkg::TASK_W-1:0]    task_id,
	input  logic [rqlh_pkg::TIME_W-1:0]    time_ns,
	input  logic [rqlh_pkg::BIN_W-1:0]     bin_select,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rqlh_pkg::STAT_W-1:0]    status,
	output logic [rqlh_pkg::BIN_W-1:0]     bin_index,
	output logic [rqlh_pkg::TIME_W-1:0]    bin_count
);

	rqlh_pkg::bk_ctrl_t bk_ctrl;
	rqlh_pkg::item_t    q_head;
	logic               q_valid;

	// Request intake and queue.
	rqlh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.task_id   (task_id),
		.time_ns   (time_ns),
		.bin_select(bin_select),
		.bk_ctrl   (bk_ctrl),
		.q_valid   (q_valid),
		.q_head    (q_head)
	);

	// Table lookup, latency binning and result register.
	rqlh_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.PROBE_LIMIT  (PROBE_LIMIT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.bk_ctrl  (bk_ctrl),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.bin_index(bin_index),
		.bin_count(bin_count)
	);

endmodule

// ===== design/rqlh_checker.sv =====
// Port-level checks for the run-queue latency histogram core, bound to the top level.
// Uses rqlh_pkg and run_queue_latency_histogram_core_macros.svh.
`include "run_queue_latency_histogram_core_macros.svh"

module rqlh_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [rqlh_pkg::STAT_W-1:0]    status,
	input logic [rqlh_pkg::BIN_W-1:0]     bin_index,
	input logic [rqlh_pkg::TIME_W-1:0]    bin_count
);

	// A stalled result stays valid and keeps its status and bin count.
	`RQLH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(bin_count) && $stable(status), "result changed while stalled")

	// A dropped wakeup reports bin zero with a zero count.
	`RQLH_ASSERT_IMP(a_drop_zero, out_valid && status == rqlh_pkg::ST_DROP, bin_index == '0 && bin_count == '0, "dropped wakeup with nonzero bin")

	// A switch without a record reports bin zero with a zero count.
	`RQLH_ASSERT_IMP(a_norec_zero, out_valid && status == rqlh_pkg::ST_NOREC, bin_index == '0 && bin_count == '0, "missing record with nonzero bin")

	// The fourth status code is never produced.
	`RQLH_ASSERT_IMP(a_status_code, out_valid, status == rqlh_pkg::ST_OK || status == rqlh_pkg::ST_DROP || status == rqlh_pkg::ST_NOREC, "undefined status code")

endmodule

bind run_queue_latency_histogram_core rqlh_checker u_rqlh_checker (.*);
